// ----- sv/length_prefixed_packet_deframer_macros.svh -----
// Assertion macros for the length-prefixed packet deframer
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_MACROS_SVH

// same-cycle implication, checked while out of reset
`define LPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, checked while out of reset
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- sv/lpd_pkg.sv -----
// Package: types and constants for the length-prefixed packet deframer
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int unsigned LPD_LENGTH_BITS = 16;

  localparam logic [7:0]  HEAD_SHORT_A = 8'hC1;
  localparam logic [7:0]  HEAD_SHORT_B = 8'hC3;
  localparam logic [7:0]  HEAD_WIDE_A  = 8'hC2;
  localparam logic [7:0]  HEAD_WIDE_B  = 8'hC4;

  localparam logic [15:0] HDR_SIZE_SHORT = 16'd2;
  localparam logic [15:0] HDR_SIZE_WIDE  = 16'd3;

  localparam logic        RST_DESCRAMBLE_ENABLE = 1'b1;
  localparam logic [7:0]  RST_XOR_KEY           = 8'h00;
  localparam logic [7:0]  RST_SUB_KEY           = 8'h00;
  localparam logic [15:0] RST_MAX_LENGTH        = 16'd8192;

  typedef enum logic [1:0] {
    CFG_DESCRAMBLE_ENABLE = 2'd0,
    CFG_XOR_KEY           = 2'd1,
    CFG_SUB_KEY           = 2'd2,
    CFG_MAX_LENGTH        = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_LEN1 = 4'b0010,
    PH_LEN2 = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_packet;
    logic       packet_start;
    logic       packet_end;
    logic       wide_length;
    logic       frame_error;
  } result_t;

endpackage

// ----- sv/length_prefixed_packet_deframer.sv -----
// Length-prefixed packet deframer: descramble, frame and mark one byte per item.
// Each accepted result is registered in out_r, or in skid_r on output stall.
// Throughput: one item per cycle while in_stall is low; a skid register absorbs one
// item of output stall; its valid bit drives in_stall, which is fully registered.
// Reset (synchronous, rst_n low) clears framing state and valid bits and restores
// descramble_enable = 1, xor_key = 0, sub_key = 0, max_length = 8192.
`timescale 1ns / 1ps

`include "length_prefixed_packet_deframer_macros.svh"

module length_prefixed_packet_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LPD_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_in_packet,
  output logic        out_packet_start,
  output logic        out_packet_end,
  output logic        out_wide_length,
  output logic        out_frame_error
);

  localparam logic [15:0] LENGTH_CAP = 16'((32'd1 << LENGTH_BITS) - 32'd1);

  logic                   descramble_enable_r;
  logic [7:0]             xor_key_r;
  logic [7:0]             sub_key_r;
  logic [15:0]            max_length_r;

  phase_t                 phase_r, phase_nxt;
  logic                   wide_flag_r, wide_flag_nxt;
  logic [7:0]             length_high_r, length_high_nxt;
  logic [LENGTH_BITS-1:0] packet_length_r, packet_length_nxt;
  logic [LENGTH_BITS-1:0] bytes_seen_r, bytes_seen_nxt;

  result_t                res_nxt;
  result_t                out_r;
  result_t                skid_r;
  logic                   out_valid_r;
  logic                   skid_valid_r;

  logic                   in_accept;
  logic [7:0]             d;
  logic                   is_head;
  logic                   is_wide_head;
  logic [15:0]            len;
  logic [15:0]            hdr;
  logic                   len_bad;
  logic [LENGTH_BITS-1:0] bytes_seen_inc;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;

  assign d = descramble_enable_r ? ((in_rx_byte ^ xor_key_r) - sub_key_r) : in_rx_byte;

  assign is_wide_head = (d == HEAD_WIDE_A) || (d == HEAD_WIDE_B);
  assign is_head      = is_wide_head || (d == HEAD_SHORT_A) || (d == HEAD_SHORT_B);

  assign len     = (phase_r == PH_LEN2) ? {length_high_r, d} : {8'h00, d};
  assign hdr     = (phase_r == PH_LEN2) ? HDR_SIZE_WIDE : HDR_SIZE_SHORT;
  assign len_bad = (len == 16'd0) || (len < hdr) || (len > max_length_r) || (len > LENGTH_CAP);
  assign bytes_seen_inc = bytes_seen_r + 1'b1;

  always_comb begin
    phase_nxt         = phase_r;
    wide_flag_nxt     = wide_flag_r;
    length_high_nxt   = length_high_r;
    packet_length_nxt = packet_length_r;
    bytes_seen_nxt    = bytes_seen_r;
    res_nxt           = '0;
    res_nxt.data_byte = d;
    case (phase_r)
      PH_HEAD: begin
        if (is_head) begin
          wide_flag_nxt        = is_wide_head;
          length_high_nxt      = 8'h00;
          packet_length_nxt    = '0;
          bytes_seen_nxt       = LENGTH_BITS'(1);
          phase_nxt            = PH_LEN1;
          res_nxt.in_packet    = 1'b1;
          res_nxt.packet_start = 1'b1;
          res_nxt.wide_length  = is_wide_head;
        end else begin
          res_nxt.frame_error  = 1'b1;
        end
      end
      PH_LEN1, PH_LEN2: begin
        if (phase_r == PH_LEN1 && wide_flag_r) begin
          length_high_nxt     = d;
          bytes_seen_nxt      = bytes_seen_inc;
          phase_nxt           = PH_LEN2;
          res_nxt.in_packet   = 1'b1;
          res_nxt.wide_length = 1'b1;
        end else begin
          res_nxt.wide_length = wide_flag_r;
          if (len_bad) begin
            res_nxt.frame_error = 1'b1;
            phase_nxt           = PH_HEAD;
            bytes_seen_nxt      = '0;
            packet_length_nxt   = '0;
          end else begin
            packet_length_nxt = len[LENGTH_BITS-1:0];
            res_nxt.in_packet = 1'b1;
            if (bytes_seen_inc == len[LENGTH_BITS-1:0]) begin
              res_nxt.packet_end = 1'b1;
              phase_nxt          = PH_HEAD;
              bytes_seen_nxt     = '0;
            end else begin
              bytes_seen_nxt = bytes_seen_inc;
              phase_nxt      = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        bytes_seen_nxt      = bytes_seen_inc;
        res_nxt.in_packet   = 1'b1;
        res_nxt.wide_length = wide_flag_r;
        if (bytes_seen_inc >= packet_length_r) begin
          res_nxt.packet_end = 1'b1;
          phase_nxt          = PH_HEAD;
          bytes_seen_nxt     = '0;
        end
      end
      default: begin
        phase_nxt = PH_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      descramble_enable_r <= RST_DESCRAMBLE_ENABLE;
      xor_key_r           <= RST_XOR_KEY;
      sub_key_r           <= RST_SUB_KEY;
      max_length_r        <= RST_MAX_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DESCRAMBLE_ENABLE: descramble_enable_r <= cfg_data[0];
        CFG_XOR_KEY:           xor_key_r           <= cfg_data[7:0];
        CFG_SUB_KEY:           sub_key_r           <= cfg_data[7:0];
        CFG_MAX_LENGTH:        max_length_r        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HEAD;
      wide_flag_r     <= 1'b0;
      length_high_r   <= 8'h00;
      packet_length_r <= '0;
      bytes_seen_r    <= '0;
    end else if (in_accept) begin
      phase_r         <= phase_nxt;
      wide_flag_r     <= wide_flag_nxt;
      length_high_r   <= length_high_nxt;
      packet_length_r <= packet_length_nxt;
      bytes_seen_r    <= bytes_seen_nxt;
    end
  end

  // output register plus one skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r && out_stall) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_r <= skid_r;
      end
    end else if (in_accept) begin
      if (out_valid_r && out_stall) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_byte    = out_r.data_byte;
  assign out_in_packet    = out_r.in_packet;
  assign out_packet_start = out_r.packet_start;
  assign out_packet_end   = out_r.packet_end;
  assign out_wide_length  = out_r.wide_length;
  assign out_frame_error  = out_r.frame_error;

  `LPD_ASSERT_NOW(a_skid_implies_out, clk, rst_n, skid_valid_r, out_valid_r)
  `LPD_ASSERT_NOW(a_err_not_in_pkt, clk, rst_n, out_valid_r, !(out_r.frame_error && out_r.in_packet))
  `LPD_ASSERT_NOW(a_start_in_pkt, clk, rst_n, out_valid_r && out_r.packet_start, out_r.in_packet)
  `LPD_ASSERT_NOW(a_count_in_pkt, clk, rst_n, phase_r != PH_HEAD, bytes_seen_r != '0)
  `LPD_ASSERT_NEXT(a_stall_to_skid, clk, rst_n, in_accept && out_valid_r && out_stall, skid_valid_r)

endmodule

// ----- tb/deframer_scoreboard_pkg.sv -----
// Scoreboard for the packet deframer: predicts the marks on each byte and checks the results
`timescale 1ns / 1ps

package deframer_scoreboard_pkg;
  import lpd_pkg::*;

  class byte_mark_scoreboard;
    logic        descramble_on;
    logic [7:0]  xor_key_q;
    logic [7:0]  sub_key_q;
    logic [15:0] max_len_q;

    phase_t      framing;
    logic        wide_hdr;
    logic [7:0]  len_hi;
    logic [15:0] pkt_len;
    logic [15:0] seen;

    result_t     expected_bytes[$];
    int unsigned fail_count;

    function new();
      descramble_on = RST_DESCRAMBLE_ENABLE;
      xor_key_q     = RST_XOR_KEY;
      sub_key_q     = RST_SUB_KEY;
      max_len_q     = RST_MAX_LENGTH;
      framing       = PH_HEAD;
      wide_hdr      = 1'b0;
      len_hi        = '0;
      pkt_len       = '0;
      seen          = '0;
      fail_count    = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [15:0] value);
      case (idx)
        CFG_DESCRAMBLE_ENABLE: descramble_on = value[0];
        CFG_XOR_KEY:           xor_key_q = value[7:0];
        CFG_SUB_KEY:           sub_key_q = value[7:0];
        CFG_MAX_LENGTH:        max_len_q = value;
        default: ;
      endcase
    endfunction

    // raw byte that descrambles to the given value under the current keys
    function logic [7:0] scramble(logic [7:0] plain);
      logic [7:0] sum;
      sum = plain + sub_key_q;
      return descramble_on ? (sum ^ xor_key_q) : plain;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void note_rx_byte(logic [7:0] rx);
      result_t     r;
      logic [7:0]  d;
      logic [7:0]  mixed;
      logic [15:0] len;
      logic [15:0] hdr;
      r = '0;
      mixed = rx ^ xor_key_q;
      d = descramble_on ? mixed - sub_key_q : rx;
      case (framing)
        PH_HEAD: begin
          if (d == HEAD_SHORT_A || d == HEAD_SHORT_B || d == HEAD_WIDE_A || d == HEAD_WIDE_B) begin
            wide_hdr = (d == HEAD_WIDE_A || d == HEAD_WIDE_B);
            len_hi = '0;
            pkt_len = '0;
            seen = 16'd1;
            framing = PH_LEN1;
            r.in_packet = 1'b1;
            r.packet_start = 1'b1;
            r.wide_length = wide_hdr;
          end else begin
            r.frame_error = 1'b1;
          end
        end
        PH_LEN1, PH_LEN2: begin
          if (framing == PH_LEN1 && wide_hdr) begin
            len_hi = d;
            seen = seen + 16'd1;
            framing = PH_LEN2;
            r.in_packet = 1'b1;
            r.wide_length = 1'b1;
          end else begin
            len = (framing == PH_LEN2) ? {len_hi, d} : {8'h00, d};
            hdr = (framing == PH_LEN2) ? HDR_SIZE_WIDE : HDR_SIZE_SHORT;
            r.wide_length = wide_hdr;
            seen = seen + 16'd1;
            if (len == 16'd0 || len < hdr || len > max_len_q) begin
              r.frame_error = 1'b1;
              framing = PH_HEAD;
              seen = '0;
              pkt_len = '0;
            end else begin
              pkt_len = len;
              r.in_packet = 1'b1;
              if (seen == pkt_len) begin
                r.packet_end = 1'b1;
                framing = PH_HEAD;
                seen = '0;
              end else begin
                framing = PH_BODY;
              end
            end
          end
        end
        default: begin
          seen = seen + 16'd1;
          r.in_packet = 1'b1;
          r.wide_length = wide_hdr;
          if (seen >= pkt_len) begin
            r.packet_end = 1'b1;
            framing = PH_HEAD;
            seen = '0;
          end
        end
      endcase
      r.data_byte = d;
      expected_bytes.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_marked_byte(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected item: data_byte %0h", got.data_byte);
        fail_count++;
        return;
      end
      want = expected_bytes.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("in_packet", want.in_packet, got.in_packet);
      compare_field("packet_start", want.packet_start, got.packet_start);
      compare_field("packet_end", want.packet_end, got.packet_end);
      compare_field("wide_length", want.wide_length, got.wide_length);
      compare_field("frame_error", want.frame_error, got.frame_error);
    endfunction
  endclass

endpackage

// ----- tb/tb_length_prefixed_packet_deframer.sv -----
// Testbench top: drives framed, broken and noise byte streams through the deframer
`timescale 1ns / 1ps

module tb_length_prefixed_packet_deframer;
  import lpd_pkg::*;
  import deframer_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 205;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_in_packet;
  logic        out_packet_start;
  logic        out_packet_end;
  logic        out_wide_length;
  logic        out_frame_error;

  byte_mark_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int          sent = 0;
  int          tx_quiet = 0;
  int          rx_quiet = 0;
  int          hold_req = 0;

  length_prefixed_packet_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_in_packet    (out_in_packet),
    .out_packet_start (out_packet_start),
    .out_packet_end   (out_packet_end),
    .out_wide_length  (out_wide_length),
    .out_frame_error  (out_frame_error)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) quiet = $urandom_range(10, 50);
    return $urandom_range(0, 9);
  endfunction

  task automatic send_raw(logic [7:0] b);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rx_byte(b);
    sent++;
  endtask

  task automatic send_frame(logic wide_kind, logic [15:0] len, int body);
    logic [7:0] head;
    if (wide_kind) head = $urandom_range(0, 1) ? HEAD_WIDE_A : HEAD_WIDE_B;
    else head = $urandom_range(0, 1) ? HEAD_SHORT_A : HEAD_SHORT_B;
    send_raw(sb.scramble(head));
    if (wide_kind) send_raw(sb.scramble(len[15:8]));
    send_raw(sb.scramble(len[7:0]));
    repeat (body) send_raw(8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic en, logic [7:0] xk, logic [7:0] sk, logic [15:0] ml);
    cfg_index_t  regs [4];
    logic [15:0] vals [4];
    regs = '{CFG_DESCRAMBLE_ENABLE, CFG_XOR_KEY, CFG_SUB_KEY, CFG_MAX_LENGTH};
    vals = '{{15'd0, en}, {8'd0, xk}, {8'd0, sk}, ml};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst();
    int   r;
    int   sel;
    int   hdr;
    int   top;
    int   hi;
    int   len;
    logic wide_kind;
    r = $urandom_range(0, 99);
    wide_kind = $urandom_range(0, 1);
    hdr = wide_kind ? 3 : 2;
    top = wide_kind ? 65535 : 255;
    if (r < 70) begin
      if (sb.max_len_q < top) top = sb.max_len_q;
      hi = ($urandom_range(0, 99) == 0) ? 300 : hdr + 20;
      if (hi > top) hi = top;
      len = $urandom_range(hdr, hi);
      send_frame(wide_kind, len[15:0], len - hdr);
    end else if (r < 85) begin
      sel = $urandom_range(0, 2);
      if (sel == 1) len = $urandom_range(1, hdr - 1);
      else if (sel == 2 && sb.max_len_q < top) len = $urandom_range(sb.max_len_q + 1, top);
      else len = 0;
      send_frame(wide_kind, len[15:0], 0);
    end else begin
      repeat ($urandom_range(1, 4)) send_raw(8'($urandom));
    end
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      int      gap;
      result_t got;
      if (hold_req > 0) begin
        gap = hold_req;
        hold_req = 0;
      end else begin
        gap = pick_gap(rx_quiet);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {out_data_byte, out_in_packet, out_packet_start, out_packet_end,
             out_wide_length, out_frame_error};
      sb.check_marked_byte(got);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int  phase_end;
    logic held;
    held = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(1'b0, 16'd2, 0);
    send_frame(1'b0, 16'd5, 3);
    send_frame(1'b1, 16'd3, 0);
    send_frame(1'b1, 16'd4, 1);
    send_raw(sb.scramble(8'h00));
    send_raw(sb.scramble(8'hFF));
    send_frame(1'b0, 16'd0, 0);
    send_frame(1'b0, 16'd1, 0);
    send_frame(1'b1, 16'd2, 0);
    send_frame(1'b1, 16'd8193, 0);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: configure(1'b1, 8'hFF, 8'hFF, 16'hFFFF);
        1: configure(1'b0, 8'($urandom), 8'($urandom), 16'd3);
        2: configure(1'b1, 8'h00, 8'hFF, 16'($urandom_range(3, 64)));
        3: configure(1'b1, 8'hFF, 8'h00, 16'($urandom_range(256, 1000)));
        4: configure(1'b0, 8'h00, 8'h00, RST_MAX_LENGTH);
        default: configure($urandom_range(0, 1), 8'($urandom), 8'($urandom),
                           16'($urandom_range(3, 65535)));
      endcase
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        if (p == 2 && !held && sent >= phase_end - 150) begin
          hold_req = 120;
          tx_quiet = 40;
          held = 1'b1;
        end
        random_burst();
      end
      wait_drained();
    end

    if (sb.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/lpd_pkg.sv
sv/length_prefixed_packet_deframer.sv
tb/deframer_scoreboard_pkg.sv
tb/tb_length_prefixed_packet_deframer.sv
